FILE: sv/dpts_pkg.sv
// Shared types, codes and constants for the delayed priority task scheduler.
`default_nettype none

package dpts_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int MAX_DISPATCH    = 16;
    localparam int N_W             = $clog2(MAX_DISPATCH + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [2:0] RK_ADDED    = 3'd0;
    localparam logic [2:0] RK_REJECTED = 3'd1;
    localparam logic [2:0] RK_REMOVED  = 3'd2;
    localparam logic [2:0] RK_CLEARED  = 3'd3;
    localparam logic [2:0] RK_DISPATCH = 3'd4;
    localparam logic [2:0] RK_NONE     = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_REMOVE_SCAN,
        ST_TICK_SCAN,
        ST_DISPATCH,
        ST_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        LN_NONE,
        LN_ADD,
        LN_DROP,
        LN_CLEAR,
        LN_READY
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     ready;
    } lane_cmd_t;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] prio;
        logic [31:0]        delay;
    } entry_t;

endpackage

`default_nettype wire

FILE: sv/delayed_priority_task_scheduler_unit.sv
// Top level: sequencer of the delayed priority task scheduler over a scanned task table.
// Clear and a rejected add need no scan; an add scans for a free slot, a remove the whole table.
// A tick runs a scan pass per dispatched task and a final pass, or stops
// after the sixteenth dispatch and flushes. A new request is taken once busy drops.
// Each result shows on the output registers in the cycle after it is formed; the receiver cannot stall.
// Reset clears the valid bits, counters and sequencer at once; no clearing pass is needed.
`default_nettype none

module delayed_priority_task_scheduler_unit #(
    parameter int TABLE_DEPTH = dpts_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [15:0]        task_id,
    input  wire logic signed [15:0] task_priority,
    input  wire logic [31:0]        release_delay,
    input  wire logic [31:0]        elapsed_time,
    output logic                    result_strobe,
    output logic [2:0]              result_kind,
    output logic [15:0]             dispatched_id,
    output logic [4:0]              removed_count,
    output logic [4:0]              occupancy,
    output logic                    last_result
);
    import dpts_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(TABLE_DEPTH);
    localparam logic [N_W-1:0]   N_LIMIT  = N_W'(MAX_DISPATCH);

    state_t state_reg;
    state_t state_next;

    logic [IDX_W:0]     scan_reg;
    logic [IDX_W:0]     scan_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   occ_next;
    logic [N_W-1:0]     n_reg;
    logic [N_W-1:0]     n_next;
    logic               pass0_reg;
    logic               pass0_next;
    logic               best_found_reg;
    logic               best_found_next;
    logic               pend_reg;
    logic               pend_next;

    logic [15:0]        id_reg;
    logic [15:0]        id_next;
    logic signed [15:0] prio_reg;
    logic signed [15:0] prio_next;
    logic [31:0]        delay_reg;
    logic [31:0]        delay_next;
    logic [31:0]        dt_reg;
    logic [31:0]        dt_next;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [IDX_W-1:0]   best_idx_next;
    logic signed [15:0] best_prio_reg;
    logic signed [15:0] best_prio_next;
    logic [IDX_W-1:0]   best_age_reg;
    logic [IDX_W-1:0]   best_age_next;
    logic [15:0]        best_id_reg;
    logic [15:0]        best_id_next;
    logic [15:0]        pend_id_reg;
    logic [15:0]        pend_id_next;
    logic [CNT_W-1:0]   pend_occ_reg;
    logic [CNT_W-1:0]   pend_occ_next;

    logic               strobe_reg;
    logic [2:0]         kind_reg;
    logic [15:0]        did_reg;
    logic [4:0]         rem_reg;
    logic [4:0]         occ_out_reg;
    logic               last_reg;

    logic               emit;
    logic [2:0]         e_kind;
    logic [15:0]        e_id;
    logic [CNT_W-1:0]   e_rem;
    logic [CNT_W-1:0]   e_occ;
    logic               e_last;

    logic [IDX_W-1:0]   scan_idx;
    logic [IDX_W-1:0]   proc_idx;
    logic               scan_done;
    logic               cand;
    logic               drop_hit;

    lane_cmd_t          lane_cmd;
    logic [IDX_W-1:0]   lane_idx;
    logic [IDX_W-1:0]   lane_rd_idx;
    logic               valid_at;
    logic               ready_at;
    logic [IDX_W-1:0]   age_at;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    entry_t             mem_rdata;

    logic [31:0]        delay_left;
    logic               delay_zero;
    logic               id_match;
    logic               better;

    assign scan_idx  = scan_reg[IDX_W-1:0];
    assign proc_idx  = IDX_W'(scan_reg - (IDX_W + 1)'(1));
    assign scan_done = (scan_reg == SCAN_END);
    assign busy      = (state_reg != ST_IDLE);

    dpts_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (scan_idx),
        .rdata (mem_rdata)
    );

    dpts_lanes #(
        .DEPTH (TABLE_DEPTH)
    ) u_lanes (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (lane_cmd),
        .cmd_idx  (lane_idx),
        .rd_idx   (lane_rd_idx),
        .valid_at (valid_at),
        .ready_at (ready_at),
        .age_at   (age_at)
    );

    dpts_alu #(
        .AGE_W (IDX_W)
    ) u_alu (
        .delay      (mem_rdata.delay),
        .step       (dt_reg),
        .id_a       (mem_rdata.id),
        .id_b       (id_reg),
        .cand_prio  (mem_rdata.prio),
        .cand_age   (age_at),
        .best_prio  (best_prio_reg),
        .best_age   (best_age_reg),
        .delay_left (delay_left),
        .delay_zero (delay_zero),
        .id_match   (id_match),
        .better     (better)
    );

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        cnt_next        = cnt_reg;
        occ_next        = occ_reg;
        n_next          = n_reg;
        pass0_next      = pass0_reg;
        best_found_next = best_found_reg;
        pend_next       = pend_reg;
        id_next         = id_reg;
        prio_next       = prio_reg;
        delay_next      = delay_reg;
        dt_next         = dt_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_age_next   = best_age_reg;
        best_id_next    = best_id_reg;
        pend_id_next    = pend_id_reg;
        pend_occ_next   = pend_occ_reg;

        emit   = 1'b0;
        e_kind = RK_NONE;
        e_id   = 16'd0;
        e_rem  = '0;
        e_occ  = occ_reg;
        e_last = 1'b0;

        lane_cmd.op    = LN_NONE;
        lane_cmd.ready = 1'b0;
        lane_idx       = proc_idx;
        lane_rd_idx    = proc_idx;

        mem_we    = 1'b0;
        mem_waddr = proc_idx;
        mem_wdata = mem_rdata;

        cand     = 1'b0;
        drop_hit = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    id_next    = task_id;
                    prio_next  = task_priority;
                    delay_next = release_delay;
                    dt_next    = elapsed_time;
                    scan_next  = '0;
                    unique case (opcode)
                        OP_ADD:
                        begin
                            if (occ_reg == FULL)
                            begin
                                emit   = 1'b1;
                                e_kind = RK_REJECTED;
                                e_last = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ADD_SCAN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            cnt_next   = '0;
                            state_next = ST_REMOVE_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            lane_cmd.op = LN_CLEAR;
                            occ_next    = '0;
                            emit        = 1'b1;
                            e_kind      = RK_CLEARED;
                            e_rem       = occ_reg;
                            e_occ       = '0;
                            e_last      = 1'b1;
                        end
                        OP_TICK:
                        begin
                            pass0_next      = 1'b1;
                            n_next          = '0;
                            pend_next       = 1'b0;
                            best_found_next = 1'b0;
                            state_next      = ST_TICK_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ADD_SCAN:
            begin
                // The table is known not to be full, so a free slot turns up.
                lane_rd_idx = scan_idx;
                lane_idx    = scan_idx;
                if (!valid_at)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = scan_idx;
                    mem_wdata.id    = id_reg;
                    mem_wdata.prio  = prio_reg;
                    mem_wdata.delay = delay_reg;
                    lane_cmd.op    = LN_ADD;
                    occ_next       = occ_reg + CNT_W'(1);
                    emit           = 1'b1;
                    e_kind         = RK_ADDED;
                    e_occ          = occ_next;
                    e_last         = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + (IDX_W + 1)'(1);
                end
            end

            ST_REMOVE_SCAN:
            begin
                // Read data is registered, so it belongs to the slot addressed in the cycle before.
                if (scan_reg != '0)
                begin
                    drop_hit = valid_at && id_match;
                    if (drop_hit)
                    begin
                        lane_cmd.op = LN_DROP;
                        cnt_next    = cnt_reg + CNT_W'(1);
                        occ_next    = occ_reg - CNT_W'(1);
                    end
                end
                if (scan_done)
                begin
                    emit       = 1'b1;
                    e_kind     = RK_REMOVED;
                    e_rem      = cnt_next;
                    e_occ      = occ_next;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + (IDX_W + 1)'(1);
                end
            end

            ST_TICK_SCAN:
            begin
                if (scan_reg != '0)
                begin
                    if (pass0_reg)
                    begin
                        // First pass applies the time step and records released slots.
                        mem_we          = 1'b1;
                        mem_wdata.delay = delay_left;
                        lane_cmd.op     = LN_READY;
                        lane_cmd.ready  = delay_zero;
                        cand            = valid_at && delay_zero;
                    end
                    else
                    begin
                        cand = valid_at && ready_at;
                    end
                    if (cand && (!best_found_reg || better))
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = proc_idx;
                        best_prio_next  = mem_rdata.prio;
                        best_age_next   = age_at;
                        best_id_next    = mem_rdata.id;
                    end
                end
                if (scan_done)
                begin
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    scan_next = scan_reg + (IDX_W + 1)'(1);
                end
            end

            ST_DISPATCH:
            begin
                // The newest dispatch is held back until it is known whether it is the last.
                if (best_found_reg)
                begin
                    lane_cmd.op   = LN_DROP;
                    lane_idx      = best_idx_reg;
                    occ_next      = occ_reg - CNT_W'(1);
                    n_next        = n_reg + N_W'(1);
                    emit          = pend_reg;
                    e_kind        = RK_DISPATCH;
                    e_id          = pend_id_reg;
                    e_occ         = pend_occ_reg;
                    pend_next     = 1'b1;
                    pend_id_next  = best_id_reg;
                    pend_occ_next = occ_next;
                    if (n_next == N_LIMIT)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        scan_next       = '0;
                        best_found_next = 1'b0;
                        pass0_next      = 1'b0;
                        state_next      = ST_TICK_SCAN;
                    end
                end
                else
                begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (pend_reg)
                    begin
                        e_kind = RK_DISPATCH;
                        e_id   = pend_id_reg;
                        e_occ  = pend_occ_reg;
                    end
                    else
                    begin
                        e_kind = RK_NONE;
                    end
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                emit       = 1'b1;
                e_kind     = RK_DISPATCH;
                e_id       = pend_id_reg;
                e_occ      = pend_occ_reg;
                e_last     = 1'b1;
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_reg       <= '0;
            cnt_reg        <= '0;
            occ_reg        <= '0;
            n_reg          <= '0;
            pass0_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            pend_reg       <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            cnt_reg        <= cnt_next;
            occ_reg        <= occ_next;
            n_reg          <= n_next;
            pass0_reg      <= pass0_next;
            best_found_reg <= best_found_next;
            pend_reg       <= pend_next;
            strobe_reg     <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        prio_reg      <= prio_next;
        delay_reg     <= delay_next;
        dt_reg        <= dt_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_age_reg  <= best_age_next;
        best_id_reg   <= best_id_next;
        pend_id_reg   <= pend_id_next;
        pend_occ_reg  <= pend_occ_next;
        if (emit)
        begin
            kind_reg    <= e_kind;
            did_reg     <= e_id;
            rem_reg     <= 5'(e_rem);
            occ_out_reg <= 5'(e_occ);
            last_reg    <= e_last;
        end
    end

    assign result_strobe = strobe_reg;
    assign result_kind   = kind_reg;
    assign dispatched_id = did_reg;
    assign removed_count = rem_reg;
    assign occupancy     = occ_out_reg;
    assign last_result   = last_reg;

endmodule

`default_nettype wire

FILE: sv/dpts_mem.sv
// Task table storage: id, priority and delay of each slot, one write and one read port.
`default_nettype none

module dpts_mem #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire dpts_pkg::entry_t wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output dpts_pkg::entry_t      rdata
);
    import dpts_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/dpts_alu.sv
// Shared datapath unit: saturating delay subtract, id match and priority/age compare.
`default_nettype none

module dpts_alu #(
    parameter int AGE_W = 4
) (
    input  wire logic [31:0]        delay,
    input  wire logic [31:0]        step,
    input  wire logic [15:0]        id_a,
    input  wire logic [15:0]        id_b,
    input  wire logic signed [15:0] cand_prio,
    input  wire logic [AGE_W-1:0]   cand_age,
    input  wire logic signed [15:0] best_prio,
    input  wire logic [AGE_W-1:0]   best_age,
    output logic [31:0]             delay_left,
    output logic                    delay_zero,
    output logic                    id_match,
    output logic                    better
);

    always_comb
    begin
        delay_left = (delay > step) ? delay - step : 32'd0;
        delay_zero = (delay_left == 32'd0);
        id_match   = (id_a == id_b);
        // A larger age means an earlier insertion, which wins a priority tie.
        better     = (cand_prio > best_prio) ||
                     ((cand_prio == best_prio) && (cand_age > best_age));
    end

endmodule

`default_nettype wire

FILE: sv/dpts_lanes.sv
// Per-slot flags: valid bits, released flags and insertion ranks, updated in parallel.
`default_nettype none

module dpts_lanes #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dpts_pkg::lane_cmd_t cmd,
    input  wire logic [IDX_W-1:0]    cmd_idx,
    input  wire logic [IDX_W-1:0]    rd_idx,
    output logic                     valid_at,
    output logic                     ready_at,
    output logic [IDX_W-1:0]         age_at
);
    import dpts_pkg::*;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH-1:0] ready_reg;
    logic [DEPTH-1:0] ready_next;
    logic [IDX_W-1:0] age_reg  [DEPTH];
    logic [IDX_W-1:0] age_next [DEPTH];
    logic [IDX_W-1:0] drop_age;

    assign valid_at = valid_reg[rd_idx];
    assign ready_at = ready_reg[rd_idx];
    assign age_at   = age_reg[rd_idx];
    assign drop_age = age_reg[cmd_idx];

    always_comb
    begin
        valid_next = valid_reg;
        ready_next = ready_reg;
        age_next   = age_reg;
        unique case (cmd.op)
            LN_ADD:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (valid_reg[i])
                    begin
                        age_next[i] = age_reg[i] + IDX_W'(1);
                    end
                end
                valid_next[cmd_idx] = 1'b1;
                age_next[cmd_idx]   = '0;
            end
            LN_DROP:
            begin
                // Close the gap in the ranks left by the dropped slot.
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (valid_reg[i] && (age_reg[i] > drop_age))
                    begin
                        age_next[i] = age_reg[i] - IDX_W'(1);
                    end
                end
                valid_next[cmd_idx] = 1'b0;
            end
            LN_CLEAR:
            begin
                valid_next = '0;
            end
            LN_READY:
            begin
                ready_next[cmd_idx] = cmd.ready;
            end
            LN_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ready_reg <= ready_next;
        age_reg   <= age_next;
    end

endmodule

`default_nettype wire

FILE: tb/tb_delayed_priority_task_scheduler_unit.sv
// Self-checking testbench for the delayed priority task scheduler: predictor, driver and monitor.
`timescale 1ns / 100ps

module tb_delayed_priority_task_scheduler_unit;

    import dpts_pkg::*;

    localparam int DEPTH       = DEF_TABLE_DEPTH;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE      = 400;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic [4:0]  removed;
        logic [4:0]  occ;
        logic        last;
    } sched_result_t;

    // Mirror of the task table; every accepted request appends its results to pending.
    class sched_scoreboard;
        logic               held   [DEPTH];
        logic [15:0]        tid    [DEPTH];
        logic signed [15:0] tprio  [DEPTH];
        logic [31:0]        tdelay [DEPTH];
        int unsigned        rank   [DEPTH];
        sched_result_t      pending[$];
        int                 mismatches;
        int                 checked;
        int                 op_count[4];

        function new();
            for (int i = 0; i < DEPTH; i++)
                held[i] = 1'b0;
            mismatches = 0;
            checked    = 0;
            for (int i = 0; i < 4; i++)
                op_count[i] = 0;
        endfunction

        function int held_count();
            int n;
            n = 0;
            for (int i = 0; i < DEPTH; i++)
                if (held[i])
                    n++;
            return n;
        endfunction

        // Entries older than the removed one close the gap in the ranks.
        function void drop(int s);
            held[s] = 1'b0;
            for (int i = 0; i < DEPTH; i++)
                if (held[i] && rank[i] > rank[s])
                    rank[i]--;
        endfunction

        function void append(sched_result_t r);
            pending.insert(pending.size(), r);
        endfunction

        function void push(logic [2:0] kind, logic [15:0] id, logic [4:0] removed);
            sched_result_t r;
            r.kind    = kind;
            r.id      = id;
            r.removed = removed;
            r.occ     = 5'(held_count());
            r.last    = 1'b0;
            append(r);
        endfunction

        function void note_request(logic [1:0] op, logic [15:0] id, logic signed [15:0] prio,
                                   logic [31:0] delay, logic [31:0] dt);
            int            slot;
            int            cnt;
            int            best;
            int            n;
            sched_result_t r;
            op_count[op]++;
            case (op)
                OP_ADD:
                begin
                    slot = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (!held[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        push(RK_REJECTED, 16'd0, 5'd0);
                    else
                    begin
                        for (int i = 0; i < DEPTH; i++)
                            if (held[i])
                                rank[i]++;
                        held[slot]   = 1'b1;
                        tid[slot]    = id;
                        tprio[slot]  = prio;
                        tdelay[slot] = delay;
                        rank[slot]   = 0;
                        push(RK_ADDED, 16'd0, 5'd0);
                    end
                end
                OP_REMOVE:
                begin
                    cnt = 0;
                    for (int i = 0; i < DEPTH; i++)
                        if (held[i] && tid[i] == id)
                        begin
                            drop(i);
                            cnt++;
                        end
                    push(RK_REMOVED, 16'd0, 5'(cnt));
                end
                OP_CLEAR:
                begin
                    cnt = held_count();
                    for (int i = 0; i < DEPTH; i++)
                        held[i] = 1'b0;
                    push(RK_CLEARED, 16'd0, 5'(cnt));
                end
                default:
                begin
                    for (int i = 0; i < DEPTH; i++)
                        if (held[i])
                            tdelay[i] = (tdelay[i] > dt) ? tdelay[i] - dt : 32'd0;
                    n = 0;
                    while (n < MAX_DISPATCH)
                    begin
                        best = -1;
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (!held[i] || tdelay[i] != 32'd0)
                                continue;
                            if (best < 0 || tprio[i] > tprio[best] ||
                                (tprio[i] == tprio[best] && rank[i] > rank[best]))
                                best = i;
                        end
                        if (best < 0)
                            break;
                        drop(best);
                        push(RK_DISPATCH, tid[best], 5'd0);
                        n++;
                    end
                    if (n == 0)
                        push(RK_NONE, 16'd0, 5'd0);
                end
            endcase
            r = pending.pop_back();
            r.last = 1'b1;
            append(r);
        endfunction

        function void check_result(logic [2:0] kind, logic [15:0] id, logic [4:0] removed,
                                   logic [4:0] occ, logic last);
            sched_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d id %h removed %0d occ %0d last %0d",
                             kind, id, removed, occ, last);
                return;
            end
            e = pending.pop_front();
            if (e.kind !== kind || e.id !== id || e.removed !== removed ||
                e.occ !== occ || e.last !== last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("result %0d mismatch: expected kind %0d id %h removed %0d occ %0d last %0d",
                             checked, e.kind, e.id, e.removed, e.occ, e.last);
                    $display("    got kind %0d id %h removed %0d occ %0d last %0d",
                             kind, id, removed, occ, last);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         opcode = OP_ADD;
    logic [15:0]        task_id = '0;
    logic signed [15:0] task_priority = '0;
    logic [31:0]        release_delay = '0;
    logic [31:0]        elapsed_time = '0;
    logic               busy;
    logic               result_strobe;
    logic [2:0]         result_kind;
    logic [15:0]        dispatched_id;
    logic [4:0]         removed_count;
    logic [4:0]         occupancy;
    logic               last_result;

    sched_scoreboard sb;

    delayed_priority_task_scheduler_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .task_id       (task_id),
        .task_priority (task_priority),
        .release_delay (release_delay),
        .elapsed_time  (elapsed_time),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .dispatched_id (dispatched_id),
        .removed_count (removed_count),
        .occupancy     (occupancy),
        .last_result   (last_result)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_result(result_kind, dispatched_id, removed_count, occupancy, last_result);
    end

    // Called at a falling edge; returns at the falling edge after busy is seen low.
    task automatic send_request(input logic [1:0] op, input logic [15:0] id,
                                input logic signed [15:0] prio, input logic [31:0] delay,
                                input logic [31:0] dt);
        opcode        = op;
        task_id       = id;
        task_priority = prio;
        release_delay = delay;
        elapsed_time  = dt;
        start         = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(op, id, prio, delay, dt);
        @(negedge clk);
    endtask

    task automatic idle_gap(input int cycles);
        start         = 1'b0;
        opcode        = 2'($urandom);
        task_id       = 16'($urandom);
        task_priority = 16'($urandom);
        release_delay = $urandom;
        elapsed_time  = $urandom;
        repeat (cycles) @(negedge clk);
    endtask

    // Mostly small ids, near-tied priorities and short delays, so the table fills,
    // removes hit and ticks release tasks; the rest is full-range noise.
    task automatic run_phase(input int idle_pct, input int count);
        int                 sel;
        logic [1:0]         op;
        logic [15:0]        id;
        logic signed [15:0] prio;
        logic [31:0]        delay;
        logic [31:0]        dt;
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                op = OP_ADD;
            else if (sel < 60)
                op = OP_REMOVE;
            else if (sel < 63)
                op = OP_CLEAR;
            else
                op = OP_TICK;
            id   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
            prio = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'(int'($urandom_range(0, 4)) - 2);
            case ($urandom_range(0, 7))
                0:       delay = 32'd0;
                1:       delay = $urandom;
                2:       delay = 32'hFFFF_FFFF;
                default: delay = $urandom_range(0, 32'h0003_0000);
            endcase
            case ($urandom_range(0, 7))
                0:       dt = 32'd0;
                1:       dt = $urandom;
                default: dt = $urandom_range(0, 32'h0002_0000);
            endcase
            // Each cycle in which a request could go out stays idle with the given odds.
            while ($urandom_range(0, 99) < idle_pct)
                idle_gap(1);
            send_request(op, id, prio, delay, dt);
        end
    endtask

    initial
    begin
        int guard;
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty table: nothing ready, remove without a match, clear of nothing.
        send_request(OP_TICK, 16'h1234, 16'sd0, 32'd0, 32'h0001_0000);
        send_request(OP_REMOVE, 16'd0, 16'sd0, 32'd0, 32'd0);
        send_request(OP_CLEAR, 16'd0, 16'sd0, 32'd0, 32'd0);
        // Fill the table with duplicate ids, extreme and tied priorities, mostly zero delay.
        for (int i = 0; i < DEPTH; i++)
            send_request(OP_ADD, 16'(i % 5),
                         (i % 4 == 0) ? -16'sd32768 : (i % 4 == 1) ? 16'sd32767 :
                         (i % 4 == 2) ? 16'sd0 : -16'sd1,
                         (i == 3) ? 32'hFFFF_FFFF : (i == 7) ? 32'h0001_0000 : 32'd0,
                         32'hFFFF_FFFF);
        send_request(OP_ADD, 16'hFFFF, 16'sd5, 32'd0, 32'd0);
        send_request(OP_REMOVE, 16'd4, 16'sd0, 32'd0, 32'd0);
        send_request(OP_TICK, 16'd0, 16'sd0, 32'd0, 32'd0);
        // A step no smaller than any delay clamps both remaining tasks to zero.
        send_request(OP_TICK, 16'd0, 16'sd0, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_ADD, 16'hFFFF, 16'sd32767, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_CLEAR, 16'd0, 16'sd0, 32'd0, 32'd0);

        run_phase(36, 52);
        run_phase(57, 52);
        run_phase(0, 52);
        idle_gap(1);

        guard = 0;
        while (sb.pending.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);

        if (sb.pending.size() != 0)
            $display("%0d expected results never arrived", sb.pending.size());
        $display("Sent %0d requests: %0d adds, %0d removes, %0d clears, %0d ticks.",
                 sb.op_count[OP_ADD] + sb.op_count[OP_REMOVE] + sb.op_count[OP_CLEAR] +
                 sb.op_count[OP_TICK], sb.op_count[OP_ADD], sb.op_count[OP_REMOVE],
                 sb.op_count[OP_CLEAR], sb.op_count[OP_TICK]);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[delayed_priority_task_scheduler_unit] OK");
        else
            $display("[delayed_priority_task_scheduler_unit] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Run timed out.");
        $display("[delayed_priority_task_scheduler_unit] ERROR");
        $finish;
    end

endmodule

FILE: delayed_priority_task_scheduler_unit.f
sv/dpts_pkg.sv
sv/dpts_mem.sv
sv/dpts_alu.sv
sv/dpts_lanes.sv
sv/delayed_priority_task_scheduler_unit.sv
tb/tb_delayed_priority_task_scheduler_unit.sv
